// ----- design/imi_pkg.sv -----
`default_nettype none
package imi_pkg;

  localparam int MASS_W = 24;
  localparam int MAG_W  = 32;
  localparam int FILT_W = 4;
  localparam int PTS_W  = 9;
  localparam int NF_W   = 5;
  localparam int THR_W  = 16;

  // Table shape; the table depths, the table addressing and the count clamps are built on these.
  localparam int MAX_POINTS  = 256;
  localparam int MAX_FILTERS = 16;

  localparam logic [MAG_W-1:0] SENTINEL_Q16 = 32'd65534719;

  typedef enum logic [1:0] {
    MODE_LOAD_MASS = 2'd0,
    MODE_LOAD_MAG  = 2'd1,
    MODE_QUERY     = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_POINTS = 2'd0,
    CFG_FILTERS = 2'd1,
    CFG_THRESH = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_idx_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SRCH_RD,
    BK_SRCH_WT,
    BK_SRCH_CMP,
    BK_PAIR_RD,
    BK_PAIR_WT,
    BK_PAIR_LAT,
    BK_MAG_RD,
    BK_MAG_WT,
    BK_MAG_LAT,
    BK_MUL,
    BK_DIV,
    BK_FIN,
    BK_EMIT
  } bk_state_t;

  // Front to back: one accepted item.
  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        point_index;
    logic [FILT_W-1:0] filter_index;
    logic [MASS_W-1:0] mass_value;
    logic [MAG_W-1:0]  magnitude_value;
  } item_t;

  typedef struct packed {
    logic [FILT_W-1:0] result_filter;
    logic [MAG_W-1:0]  magnitude;
    logic              is_sentinel;
    logic              last_filter;
  } result_t;

endpackage
`default_nettype wire

// ----- design/imi_front.sv -----
`default_nettype none
// Accepts items into a short queue that decouples the port from the back end.
module imi_front #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire imi_pkg::item_t push_item,
  output logic                full,
  output logic                q_valid,
  output imi_pkg::item_t      q_item,
  input  wire logic           q_take
);
  import imi_pkg::*;

  localparam int AW = $clog2(DEPTH);

  item_t         mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem[rp_r];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_comb begin
    wp_nxt  = do_push ? ((wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop  ? ((rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- design/imi_divider.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle, truncating signed result.
module imi_divider #(
  parameter int NW = 57,
  parameter int DW = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] num,
  input  wire logic signed [DW-1:0] den,
  output logic                      done,
  output logic signed [NW-1:0]      quo
);
  import imi_pkg::*;

  localparam int CW = $clog2(NW+1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r;
  logic          neg_r, busy_r, busy_nxt, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   trial;
  logic          done_r;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; busy_nxt = busy_r; cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt    = num[NW-1] ? NW'(-num) : NW'(num);
      rem_nxt  = '0;
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Both operands are divided as magnitudes; the quotient takes the sign of
  // their product, which truncates toward zero.
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      d_r <= den[DW-1] ? DW'(-den) : DW'(den);
      neg_r <= num[NW-1] ^ den[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule
`default_nettype wire

// ----- design/imi_back.sv -----
`default_nettype none
// Executes loads and queries: holds both tables, runs the search and the
// per-filter interpolation, and feeds a two-entry result queue.
module imi_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire imi_pkg::item_t              q_item,
  output logic                             q_take,
  input  wire logic [imi_pkg::PTS_W-1:0]   points_in_use,
  input  wire logic [imi_pkg::NF_W-1:0]    filters_in_use,
  input  wire logic [imi_pkg::THR_W-1:0]   zero_threshold,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output imi_pkg::result_t                 out_res
);
  import imi_pkg::*;

  localparam int PW  = (MAX_POINTS  > 1) ? $clog2(MAX_POINTS)  : 1;
  localparam int FW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int NPW = PW + 1;
  localparam int NW  = 33 + 25;

  logic [MASS_W-1:0] mass_mem [MAX_POINTS];
  logic [MAG_W-1:0]  mag_mem  [MAX_POINTS*MAX_FILTERS];

  bk_state_t st_r, st_nxt;

  logic [NPW-1:0]    n_eff, first_r, first_nxt, count_r, count_nxt;
  logic [NPW-1:0]    half, probe;
  logic [PW-1:0]     p_r, p_nxt;
  logic [FILT_W:0]   nf_eff;
  logic [FILT_W:0]   f_r, f_nxt;
  logic [MASS_W-1:0] q_mass_r;
  logic [MASS_W-1:0] m0_r, m1_r, mrd_r;
  logic [MAG_W-1:0]  y0_r, ydat_r;
  logic [PW-1:0]     mrd_addr;
  logic [PW+FW-1:0]  yrd_addr;
  logic              sel1_r, sel1_nxt;
  logic signed [32:0] dy;
  logic signed [24:0] dq_r;
  logic signed [NW-1:0] prod_w, prod_r;
  logic signed [24:0] dm;
  logic               div_start, div_done;
  logic signed [NW-1:0] quo;
  logic signed [NW-1:0] sum;
  logic signed [MAG_W-1:0] v_sat;
  logic [MAG_W-1:0]   absv;
  logic               sent;
  result_t            res_r, res_nxt;
  logic               wr_mass, wr_mag;

  // Two-entry result queue.
  result_t rq [2];
  logic    rq_wp_r, rq_rp_r;
  logic [1:0] rq_cnt_r;
  logic    rq_push, rq_pop;

  always_comb begin
    if (points_in_use < PTS_W'(2)) n_eff = NPW'(2);
    else if (points_in_use > PTS_W'(MAX_POINTS)) n_eff = NPW'(MAX_POINTS);
    else n_eff = NPW'(points_in_use);
    if (filters_in_use == '0) nf_eff = (FILT_W+1)'(1);
    else if (filters_in_use > NF_W'(MAX_FILTERS)) nf_eff = (FILT_W+1)'(MAX_FILTERS);
    else nf_eff = (FILT_W+1)'(filters_in_use);
  end

  assign half  = count_r >> 1;
  assign probe = first_r + half;

  // Loads write the tables directly from the queue head.
  assign wr_mass = (st_r == BK_IDLE) && q_valid && (q_item.mode == MODE_LOAD_MASS)
                   && (32'(q_item.point_index) < MAX_POINTS);
  assign wr_mag  = (st_r == BK_IDLE) && q_valid && (q_item.mode == MODE_LOAD_MAG)
                   && (32'(q_item.point_index) < MAX_POINTS)
                   && (32'(q_item.filter_index) < MAX_FILTERS);

  // The pair address is held through the wait cycle so the second read
  // returns the same point.
  always_comb begin
    mrd_addr = PW'(probe);
    if (st_r == BK_PAIR_RD || st_r == BK_PAIR_WT)
      mrd_addr = sel1_r ? PW'(p_r + 1'b1) : p_r;
    yrd_addr = {(sel1_r ? PW'(p_r + 1'b1) : p_r), FW'(f_r)};
  end

  always_ff @(posedge clk) begin
    if (wr_mass) mass_mem[PW'(q_item.point_index)] <= q_item.mass_value;
    if (wr_mag)
      mag_mem[{PW'(q_item.point_index), FW'(q_item.filter_index)}] <= q_item.magnitude_value;
    mrd_r  <= mass_mem[mrd_addr];
    ydat_r <= mag_mem[yrd_addr];
  end

  assign dm        = $signed({1'b0, m1_r}) - $signed({1'b0, m0_r});
  assign div_start = (st_r == BK_MUL);
  assign sum       = NW'($signed(y0_r)) + quo;

  always_comb begin
    if (m1_r == m0_r) v_sat = $signed(y0_r);
    else if (sum > NW'(64'sh7FFFFFFF)) v_sat = 32'sh7FFFFFFF;
    else if (sum < -NW'(64'sh80000000)) v_sat = -32'sh80000000;
    else v_sat = sum[MAG_W-1:0];
    absv = v_sat[MAG_W-1] ? MAG_W'(-v_sat) : MAG_W'(v_sat);
    // |INT32_MIN| wraps to itself; it is far above any threshold.
    sent = !(v_sat == -32'sh80000000) && (absv < MAG_W'(zero_threshold));
  end

  imi_divider #(.NW(NW), .DW(25)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(prod_r), .den(dm), .done(div_done), .quo(quo)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (q_valid && q_item.mode == MODE_QUERY) st_nxt = BK_SRCH_RD;
      BK_SRCH_RD:  st_nxt = (count_r == '0) ? BK_PAIR_RD : BK_SRCH_WT;
      BK_SRCH_WT:  st_nxt = BK_SRCH_CMP;
      BK_SRCH_CMP: st_nxt = BK_SRCH_RD;
      BK_PAIR_RD:  st_nxt = BK_PAIR_WT;
      BK_PAIR_WT:  st_nxt = BK_PAIR_LAT;
      BK_PAIR_LAT: st_nxt = sel1_r ? BK_MAG_RD : BK_PAIR_RD;
      BK_MAG_RD:   st_nxt = BK_MAG_WT;
      BK_MAG_WT:   st_nxt = BK_MAG_LAT;
      BK_MAG_LAT:  st_nxt = sel1_r ? BK_MUL : BK_MAG_RD;
      BK_MUL:      st_nxt = BK_DIV;
      BK_DIV:      st_nxt = div_done ? BK_FIN : BK_DIV;
      BK_FIN:      st_nxt = BK_EMIT;
      BK_EMIT: if (rq_cnt_r != 2'd2)
        st_nxt = (f_r + 1'b1 == nf_eff) ? BK_IDLE : BK_MAG_RD;
      default:     st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_take    = 1'b0;
    first_nxt = first_r;
    count_nxt = count_r;
    p_nxt     = p_r;
    f_nxt     = f_r;
    sel1_nxt  = sel1_r;
    rq_push   = 1'b0;
    res_nxt   = res_r;
    unique case (st_r)
      BK_IDLE: begin
        q_take = q_valid;
        first_nxt = '0; count_nxt = n_eff; f_nxt = '0; sel1_nxt = 1'b0;
      end
      BK_SRCH_RD: if (count_r == '0) begin
        if (first_r >= n_eff) p_nxt = PW'(n_eff - NPW'(2));
        else if (first_r != '0) p_nxt = PW'(first_r - 1'b1);
        else p_nxt = '0;
      end
      BK_SRCH_CMP: begin
        if (mrd_r < q_mass_r) begin
          first_nxt = probe + 1'b1;
          count_nxt = count_r - half - 1'b1;
        end else begin
          count_nxt = half;
        end
      end
      BK_PAIR_LAT: sel1_nxt = !sel1_r;
      BK_MAG_LAT:  sel1_nxt = !sel1_r;
      BK_FIN: begin
        res_nxt.result_filter = FILT_W'(f_r);
        res_nxt.magnitude     = sent ? SENTINEL_Q16 : MAG_W'(v_sat);
        res_nxt.is_sentinel   = sent;
        res_nxt.last_filter   = (f_r + 1'b1 == nf_eff);
      end
      BK_EMIT: if (rq_cnt_r != 2'd2) begin
        rq_push = 1'b1;
        f_nxt   = f_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt; count_r <= count_nxt; p_r <= p_nxt;
    f_r <= f_nxt; sel1_r <= sel1_nxt; res_r <= res_nxt;
    if (st_r == BK_IDLE) q_mass_r <= q_item.mass_value;
    if (st_r == BK_PAIR_LAT) begin
      if (sel1_r) m1_r <= mrd_r; else m0_r <= mrd_r;
    end
    if (st_r == BK_MAG_LAT && !sel1_r) y0_r <= ydat_r;
    if (st_r == BK_MAG_RD && !sel1_r)
      dq_r <= $signed({1'b0, q_mass_r}) - $signed({1'b0, m0_r});
  end

  // A 33 by 25 bit signed product, registered in the cycle before the divider starts.
  assign dy     = $signed({ydat_r[31], ydat_r}) - $signed({y0_r[31], y0_r});
  assign prod_w = dy * dq_r;

  always_ff @(posedge clk) begin
    if (st_r == BK_MAG_LAT && sel1_r) prod_r <= prod_w;
  end

  assign rq_pop = out_pop && !out_empty;
  assign out_empty = (rq_cnt_r == '0);
  assign out_res = rq[rq_rp_r];

  always_ff @(posedge clk) begin
    if (rq_push) rq[rq_wp_r] <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; rq_wp_r <= 1'b0; rq_rp_r <= 1'b0; rq_cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (rq_push) rq_wp_r <= !rq_wp_r;
      if (rq_pop)  rq_rp_r <= !rq_rp_r;
      rq_cnt_r <= rq_cnt_r + 2'(rq_push) - 2'(rq_pop);
    end
  end
endmodule
`default_nettype wire

// ----- design/isochrone_mass_interpolator_unit.sv -----
`default_nettype none
// A load is written into its table from the queue head while the back end is idle; no result.
// A query is taken from the queue and binary-searched over the mass table (at most nine
// probes), then the pair masses are fetched; for each filter the two magnitudes are fetched,
// multiplied and divided in the one-bit-per-cycle divider. One query is worked at a time; a full
// result queue stalls it. Reset (rst_n low, synchronous) empties both queues and restores the
// configuration registers and the sequencer state; the tables hold garbage until loaded.
module isochrone_mass_interpolator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_point_index,
  input  wire logic [3:0]  in_filter_index,
  input  wire logic [23:0] in_mass_value,
  input  wire logic signed [31:0] in_magnitude_value,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       out_result_filter,
  output logic signed [31:0] out_magnitude,
  output logic             out_is_sentinel,
  output logic             out_last_filter,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import imi_pkg::*;

  // Configuration registers; the user must write them only while the block is idle (not enforced).
  logic [PTS_W-1:0] points_r;
  logic [NF_W-1:0]  filters_r;
  logic [THR_W-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= PTS_W'(2); filters_r <= NF_W'(1); thresh_r <= THR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POINTS:  points_r  <= cfg_data[PTS_W-1:0];
        CFG_FILTERS: filters_r <= cfg_data[NF_W-1:0];
        CFG_THRESH:  thresh_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  item_t   in_item, q_item;
  logic    q_valid, q_take;
  result_t res;

  assign in_item = '{mode: in_mode, point_index: in_point_index,
                     filter_index: in_filter_index, mass_value: in_mass_value,
                     magnitude_value: in_magnitude_value};

  // The front queue lets loads pile up while a query is being worked.
  imi_front #(.DEPTH(4)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(in_item), .full(full),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  imi_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .points_in_use(points_r), .filters_in_use(filters_r), .zero_threshold(thresh_r),
    .out_empty(empty), .out_pop(pop), .out_res(res)
  );

  assign out_result_filter = res.result_filter;
  assign out_magnitude     = res.magnitude;
  assign out_is_sentinel   = res.is_sentinel;
  assign out_last_filter   = res.last_filter;
endmodule
`default_nettype wire

// ----- design/imi_checker.sv -----
`default_nettype none
module imi_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic signed [31:0] out_magnitude,
  input wire logic        out_is_sentinel
);
  import imi_pkg::*;

  a_sent_value: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_sentinel) |-> (out_magnitude == SENTINEL_Q16))
    else $error("sentinel flag without sentinel value");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_magnitude)))
    else $error("waiting result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not clear after reset");
endmodule

bind isochrone_mass_interpolator_unit imi_checker u_chk (
  .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty), .pop(pop),
  .out_magnitude(out_magnitude), .out_is_sentinel(out_is_sentinel)
);
`default_nettype wire
